// File: sv/ilf_pkg.sv
// package for the two-plane incremental line fit
// types, widths and constants shared by every module; no dependencies
package ilf_pkg;

    localparam int MAX_HITS  = 255;
    localparam int CNT_W     = $clog2(MAX_HITS + 1);
    localparam int SUM_W     = 64;
    localparam int PROD_W    = 128;
    localparam int QUEUE_D   = 2;
    localparam int QPTR_W    = 1;

    typedef enum logic
    {
        CMD_ADD   = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic                command;
        logic        [15:0]  weight_xy;
        logic signed [15:0]  conf_x;
        logic signed [15:0]  conf_y;
        logic        [15:0]  weight_z;
        logic signed [15:0]  path_s;
        logic signed [15:0]  hit_z;
    } hit_t;

    typedef struct packed
    {
        logic signed [31:0]  xy_intercept;
        logic signed [31:0]  xy_slope;
        logic signed [31:0]  sz_intercept;
        logic signed [31:0]  sz_slope;
        logic                xy_solved;
        logic                sz_solved;
        logic        [7:0]   hits_in_fit;
    } fit_t;

    // classified work handed from front to back
    typedef struct packed
    {
        logic                clear;
        logic                add;
        logic signed [16:0]  w_xy;
        logic signed [16:0]  u_xy;
        logic signed [16:0]  v_xy;
        logic signed [16:0]  w_sz;
        logic signed [16:0]  u_sz;
        logic signed [16:0]  v_sz;
        logic        [7:0]   hits;
    } job_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_UU,
        ST_WU,
        ST_WUU,
        ST_ACC,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_SOLVE,
        ST_DIV,
        ST_NEXT,
        ST_OUT
    } st_t;

endpackage

// File: sv/ilf_if.sv
// valid/ready channel carrying one item of type T per beat
// depends on nothing
interface ilf_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/incremental_line_fit_two_planes.sv
// two-plane incremental weighted line fit, top level
// an add is valid after both planes: per plane the update steps, six products on the shared
// 4-step 64x64 multiplier and, if the determinant is nonzero, two divisions on the
// 2-bit-per-cycle divider; a plane with zero determinant skips the divisions; a clear or an
// ignored add skips both planes; one item in the back end at a time; reset clears sums,
// coefficients, count and handshakes
module incremental_line_fit_two_planes
(
    input  logic clk,
    input  logic rst_n,
    ilf_if.sink   hit_in,
    ilf_if.source fit_out
);
    import ilf_pkg::*;

    logic q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
    job_t q_wr_job, q_rd_job;

    ilf_front u_front (.clk, .rst_n, .in_valid(hit_in.valid), .in_ready(hit_in.ready),
                       .in_hit(hit_in.data), .q_valid(q_wr_valid), .q_ready(q_wr_ready),
                       .q_job(q_wr_job));

    ilf_queue u_queue (.clk, .rst_n, .wr_valid(q_wr_valid), .wr_ready(q_wr_ready),
                       .wr_job(q_wr_job), .rd_valid(q_rd_valid), .rd_ready(q_rd_ready),
                       .rd_job(q_rd_job));

    ilf_back u_back (.clk, .rst_n, .q_valid(q_rd_valid), .q_ready(q_rd_ready),
                     .q_job(q_rd_job), .out_valid(fit_out.valid), .out_ready(fit_out.ready),
                     .out_fit(fit_out.data));
endmodule

// File: sv/ilf_front.sv
// front end: takes hits, tracks hit count, classifies add/clear/ignore
// uses ilf_pkg; feeds the job queue
module ilf_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ilf_pkg::hit_t in_hit,
    output logic          q_valid,
    input  logic          q_ready,
    output ilf_pkg::job_t q_job
);
    import ilf_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             full;

    assign full     = (count_reg == CNT_W'(MAX_HITS));
    assign in_ready = q_ready;
    assign q_valid  = in_valid;

    always_comb
    begin
        count_next = count_reg;
        if (in_valid && q_ready)
        begin
            if (cmd_t'(in_hit.command) == CMD_CLEAR)
                count_next = '0;
            else if (!full)
                count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        q_job.clear = (cmd_t'(in_hit.command) == CMD_CLEAR);
        q_job.add   = !q_job.clear && !full;
        q_job.w_xy  = {1'b0, in_hit.weight_xy};
        q_job.u_xy  = 17'(in_hit.conf_x);
        q_job.v_xy  = 17'(in_hit.conf_y);
        q_job.w_sz  = {1'b0, in_hit.weight_z};
        q_job.u_sz  = 17'(in_hit.path_s);
        q_job.v_sz  = 17'(in_hit.hit_z);
        if (count_next > CNT_W'(255))
            q_job.hits = 8'd255;
        else
            q_job.hits = 8'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end
endmodule

// File: sv/ilf_queue.sv
// two-entry job queue between front and back
// uses ilf_pkg
module ilf_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  ilf_pkg::job_t wr_job,
    output logic          rd_valid,
    input  logic          rd_ready,
    output ilf_pkg::job_t rd_job
);
    import ilf_pkg::*;

    job_t              mem_reg [QUEUE_D];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic              push, pop;

    assign wr_ready = (cnt_reg != (QPTR_W+1)'(QUEUE_D));
    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end
endmodule

// File: sv/ilf_mul.sv
// 64x64 signed multiplier, four 32x32 partial products accumulated in turn
// uses ilf_pkg
module ilf_mul
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [ilf_pkg::SUM_W-1:0]   a,
    input  logic signed [ilf_pkg::SUM_W-1:0]   b,
    output logic                               done,
    output logic signed [ilf_pkg::PROD_W-1:0]  p
);
    import ilf_pkg::*;

    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg;
    logic [1:0]   step_reg;
    logic         busy_reg, done_reg;
    logic [127:0] acc_reg;
    logic [31:0]  x, y;
    logic [63:0]  pp;
    logic [127:0] sh;

    always_comb
    begin
        x  = step_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        y  = step_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        pp = 64'(x) * 64'(y);
        sh = 128'(pp) << (32 * (int'(step_reg[0]) + int'(step_reg[1])));
    end

    assign done = done_reg;
    assign p    = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= a[63] ? 64'(-a) : 64'(a);
            mb_reg  <= b[63] ? 64'(-b) : 64'(b);
            neg_reg <= a[63] ^ b[63];
            acc_reg <= '0;
        end
        else if (busy_reg)
            acc_reg <= acc_reg + sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// File: sv/ilf_div.sv
// restoring divider: (|num| << k) / |den|, 2 quotient bits per cycle,
// saturated to signed 32 bits; uses ilf_pkg
module ilf_div
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [ilf_pkg::PROD_W-1:0]  num,
    input  logic signed [ilf_pkg::PROD_W-1:0]  den,
    input  logic        [4:0]                  k,
    output logic                               done,
    output logic        [31:0]                 quot
);
    import ilf_pkg::*;

    // numerator magnitude <= 2^127 shifted by at most 16 fits 144 bits
    logic [143:0] n_reg;
    logic [127:0] d_reg;
    logic [128:0] r_reg;
    logic [32:0]  q_reg;
    logic         qovf_reg;
    logic         neg_reg;
    logic [6:0]   cnt_reg;
    logic         busy_reg, done_reg;
    logic [128:0] r1, r2, t1, t2;
    logic         b1, b2;
    logic [127:0] mn;

    always_comb
    begin
        r1 = {r_reg[127:0], n_reg[143]};
        t1 = r1 - {1'b0, d_reg};
        b1 = !t1[128];
        if (b1)
            r1 = t1;
        r2 = {r1[127:0], n_reg[142]};
        t2 = r2 - {1'b0, d_reg};
        b2 = !t2[128];
        if (b2)
            r2 = t2;
        mn = num[127] ? 128'(-num) : 128'(num);
    end

    assign done = done_reg;

    always_comb
    begin
        if (!neg_reg)
            quot = (qovf_reg || q_reg > 33'h07FFFFFFF) ? 32'h7FFFFFFF : q_reg[31:0];
        else
            quot = (qovf_reg || q_reg > 33'h080000000) ? 32'h80000000
                                                       : 32'(-q_reg[31:0]);
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= 144'(mn) << k;
            d_reg    <= den[127] ? 128'(-den) : 128'(den);
            neg_reg  <= num[127] ^ den[127];
            r_reg    <= '0;
            q_reg    <= '0;
            qovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            n_reg    <= {n_reg[141:0], 2'b00};
            r_reg    <= r2;
            q_reg    <= {q_reg[30:0], b1, b2};
            qovf_reg <= qovf_reg || q_reg[32] || q_reg[31];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 7'd71)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// File: sv/ilf_back.sv
// back end: updates sums, forms determinants and numerators, divides
// uses ilf_pkg, ilf_mul, ilf_div
module ilf_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  ilf_pkg::job_t q_job,
    output logic          out_valid,
    input  logic          out_ready,
    output ilf_pkg::fit_t out_fit
);
    import ilf_pkg::*;

    st_t  st_reg, st_next;
    job_t job_reg;
    logic plane_reg;                       // 0 xy, 1 sz
    logic signed [SUM_W-1:0] s_reg [2][5];
    logic signed [33:0] uu_reg, uv_reg, wu_reg, wv_reg;
    logic signed [50:0] wuu_reg, wuv_reg;
    logic signed [PROD_W-1:0] pa_reg, d_reg, n1_reg, n2_reg;
    logic [31:0] coef_reg [4];
    logic [1:0]  solved_reg;
    logic        dsel_reg;                 // which numerator is in the divider
    logic        out_valid_reg;
    fit_t        fit_reg;

    logic signed [16:0]       w, u, v;
    logic signed [SUM_W-1:0]  ma, mb;
    logic                     mstart, mdone, dstart, ddone;
    logic signed [PROD_W-1:0] mp, dnum;
    logic [31:0]              dq;
    logic [4:0]               dk;
    logic                     nsel;

    assign w = plane_reg ? job_reg.w_sz : job_reg.w_xy;
    assign u = plane_reg ? job_reg.u_sz : job_reg.u_xy;
    assign v = plane_reg ? job_reg.v_sz : job_reg.v_xy;

    ilf_mul u_mul (.clk, .rst_n, .start(mstart), .a(ma), .b(mb), .done(mdone), .p(mp));

    // the slope division starts in the cycle the intercept division finishes
    assign nsel = dsel_reg || ddone;
    assign dnum = nsel ? n2_reg : n1_reg;
    assign dk   = nsel ? 5'd16 : (plane_reg ? 5'd12 : 5'd2);
    ilf_div u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(d_reg), .k(dk),
                   .done(ddone), .quot(dq));

    assign q_ready   = (st_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_fit   = fit_reg;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:  if (q_valid && q_ready)
                          st_next = (q_job.add) ? ST_UU : ST_OUT;
            ST_UU:    st_next = ST_WU;
            ST_WU:    st_next = ST_WUU;
            ST_WUU:   st_next = ST_ACC;
            ST_ACC:   st_next = ST_M0;
            ST_M0:    if (mdone) st_next = ST_M1;
            ST_M1:    if (mdone) st_next = ST_M2;
            ST_M2:    if (mdone) st_next = ST_M3;
            ST_M3:    if (mdone) st_next = ST_M4;
            ST_M4:    if (mdone) st_next = ST_M5;
            ST_M5:    if (mdone) st_next = ST_SOLVE;
            ST_SOLVE: st_next = (d_reg == '0) ? ST_NEXT : ST_DIV;
            ST_DIV:   if (ddone && dsel_reg) st_next = ST_NEXT;
            ST_NEXT:  st_next = plane_reg ? ST_OUT : ST_UU;
            ST_OUT:   st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    // multiplier operands and starts, divider starts
    always_comb
    begin
        ma = '0;
        mb = '0;
        mstart = 1'b0;
        dstart = 1'b0;
        unique case (st_reg)
            // sums are written this cycle, so feed the updated values
            ST_ACC:
            begin
                ma = s_reg[plane_reg][0] + SUM_W'(w);
                mb = s_reg[plane_reg][2] + SUM_W'(wuu_reg);
                mstart = 1'b1;
            end
            ST_M0:    begin ma = s_reg[plane_reg][1]; mb = s_reg[plane_reg][1]; mstart = mdone; end
            ST_M1:    begin ma = s_reg[plane_reg][3]; mb = s_reg[plane_reg][2]; mstart = mdone; end
            ST_M2:    begin ma = s_reg[plane_reg][4]; mb = s_reg[plane_reg][1]; mstart = mdone; end
            ST_M3:    begin ma = s_reg[plane_reg][4]; mb = s_reg[plane_reg][0]; mstart = mdone; end
            ST_M4:    begin ma = s_reg[plane_reg][3]; mb = s_reg[plane_reg][1]; mstart = mdone; end
            ST_SOLVE: dstart = (d_reg != '0);
            ST_DIV:   dstart = ddone && !dsel_reg;
            default:  ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_IDLE:  if (q_valid && q_ready) job_reg <= q_job;
            ST_UU:    begin uu_reg <= 34'(u) * 34'(u); uv_reg <= 34'(u) * 34'(v); end
            ST_WU:    begin wu_reg <= 34'(w) * 34'(u); wv_reg <= 34'(w) * 34'(v); end
            ST_WUU:
            begin
                wuu_reg <= 51'(w) * 51'(uu_reg);
                wuv_reg <= 51'(w) * 51'(uv_reg);
            end
            ST_M0:    if (mdone) pa_reg <= mp;
            ST_M1:    if (mdone) d_reg <= pa_reg - mp;
            ST_M2:    if (mdone) pa_reg <= mp;
            ST_M3:    if (mdone) n1_reg <= pa_reg - mp;
            ST_M4:    if (mdone) pa_reg <= mp;
            ST_M5:    if (mdone) n2_reg <= pa_reg - mp;
            ST_OUT:
            begin
                fit_reg.xy_intercept <= coef_reg[0];
                fit_reg.xy_slope     <= coef_reg[1];
                fit_reg.sz_intercept <= coef_reg[2];
                fit_reg.sz_slope     <= coef_reg[3];
                fit_reg.xy_solved    <= solved_reg[0];
                fit_reg.sz_solved    <= solved_reg[1];
                fit_reg.hits_in_fit  <= job_reg.hits;
            end
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            plane_reg     <= 1'b0;
            dsel_reg      <= 1'b0;
            solved_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < 2; p++)
                for (int i = 0; i < 5; i++)
                    s_reg[p][i] <= '0;
            for (int i = 0; i < 4; i++)
                coef_reg[i] <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE:
                    if (q_valid && q_ready)
                    begin
                        plane_reg  <= 1'b0;
                        dsel_reg   <= 1'b0;
                        solved_reg <= '0;
                        if (q_job.clear)
                            for (int p = 0; p < 2; p++)
                                for (int i = 0; i < 5; i++)
                                    s_reg[p][i] <= '0;
                    end
                ST_ACC:
                begin
                    s_reg[plane_reg][0] <= s_reg[plane_reg][0] + SUM_W'(w);
                    s_reg[plane_reg][1] <= s_reg[plane_reg][1] + SUM_W'(wu_reg);
                    s_reg[plane_reg][2] <= s_reg[plane_reg][2] + SUM_W'(wuu_reg);
                    s_reg[plane_reg][3] <= s_reg[plane_reg][3] + SUM_W'(wv_reg);
                    s_reg[plane_reg][4] <= s_reg[plane_reg][4] + SUM_W'(wuv_reg);
                end
                ST_SOLVE:
                begin
                    dsel_reg <= 1'b0;
                    if (d_reg != '0)
                        solved_reg[plane_reg] <= 1'b1;
                end
                ST_DIV:
                    if (ddone)
                    begin
                        coef_reg[{plane_reg, dsel_reg}] <= dq;
                        dsel_reg <= 1'b1;
                    end
                ST_NEXT:
                begin
                    plane_reg <= 1'b1;
                    dsel_reg  <= 1'b0;
                end
                ST_OUT:   out_valid_reg <= 1'b1;
                default:  ;
            endcase
        end
    end
endmodule

// File: dv/tb.sv
// testbench for incremental_line_fit_two_planes: drives hits, predicts both plane fits
// depends on sv/ilf_pkg.sv, sv/ilf_if.sv and the block's rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ilf_pkg::*;

    typedef logic signed [63:0] sums_t [5];

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ilf_if #(.T(hit_t)) hit_ch ();
    ilf_if #(.T(fit_t)) fit_ch ();

    incremental_line_fit_two_planes dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .hit_in  (hit_ch.sink),
        .fit_out (fit_ch.source)
    );

    always #5 clk = ~clk;

    hit_t  pending_hits[$];
    fit_t  expected_fits[$];
    sums_t xy_acc;
    sums_t sz_acc;
    logic  [31:0] coef[4];
    int    fit_hits;
    int    errors;
    int    fits_seen;
    int    tx_wait;
    int    rx_wait;
    bit    long_stall_done;
    bit    calm;
    int    idle_cycles;

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 99) == 0)
            calm = ~calm;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // (|n| << k) / |d| truncated inside 128 bits, signed, saturated to 32 bits
    function automatic logic [31:0] scaled_quotient(logic signed [127:0] n,
                                                    logic signed [127:0] d, int k);
        logic [127:0] mn;
        logic [127:0] md;
        logic [127:0] q;
        bit neg;
        neg = n[127] ^ d[127];
        mn = n[127] ? 128'(-n) : 128'(n);
        md = d[127] ? 128'(-d) : 128'(d);
        q = (mn << k) / md;
        if (!neg)
            return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        return (q > 128'h8000_0000) ? 32'h8000_0000 : 32'(-q[31:0]);
    endfunction

    function automatic bit solve_normal(sums_t s, int k1, int k2,
                                        inout logic [31:0] a1, inout logic [31:0] a2);
        logic signed [127:0] s11;
        logic signed [127:0] s12;
        logic signed [127:0] s22;
        logic signed [127:0] g1;
        logic signed [127:0] g2;
        logic signed [127:0] det;
        s11 = s[0];
        s12 = s[1];
        s22 = s[2];
        g1 = s[3];
        g2 = s[4];
        det = s11 * s22 - s12 * s12;
        if (det == 0)
            return 1'b0;
        a1 = scaled_quotient(g1 * s22 - g2 * s12, det, k1);
        a2 = scaled_quotient(g2 * s11 - g1 * s12, det, k2);
        return 1'b1;
    endfunction

    function automatic void accumulate(ref sums_t s, input logic [15:0] w,
                                       input logic signed [15:0] u,
                                       input logic signed [15:0] v);
        logic signed [63:0] w64;
        logic signed [63:0] u64;
        logic signed [63:0] v64;
        w64 = $signed({48'b0, w});
        u64 = u;
        v64 = v;
        s[0] += w64;
        s[1] += w64 * u64;
        s[2] += w64 * (u64 * u64);
        s[3] += w64 * v64;
        s[4] += w64 * (u64 * v64);
    endfunction

    task automatic predict_fit(hit_t h);
        fit_t f;
        f = '0;
        if (h.command == CMD_CLEAR)
        begin
            foreach (xy_acc[i])
            begin
                xy_acc[i] = '0;
                sz_acc[i] = '0;
            end
            fit_hits = 0;
        end
        else if (fit_hits < MAX_HITS)
        begin
            fit_hits++;
            accumulate(xy_acc, h.weight_xy, h.conf_x, h.conf_y);
            accumulate(sz_acc, h.weight_z, h.path_s, h.hit_z);
            f.xy_solved = solve_normal(xy_acc, 2, 16, coef[0], coef[1]);
            f.sz_solved = solve_normal(sz_acc, 12, 16, coef[2], coef[3]);
        end
        f.xy_intercept = coef[0];
        f.xy_slope = coef[1];
        f.sz_intercept = coef[2];
        f.sz_slope = coef[3];
        f.hits_in_fit = (fit_hits > 255) ? 8'd255 : 8'(fit_hits);
        expected_fits.push_back(f);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // hit driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_ch.valid <= 1'b0;
            hit_ch.data <= '0;
            tx_wait <= 0;
        end
        else
        begin
            if (hit_ch.valid && hit_ch.ready)
                predict_fit(hit_ch.data);
            if (!hit_ch.valid || hit_ch.ready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait <= tx_wait - 1;
                    hit_ch.valid <= 1'b0;
                end
                else if (pending_hits.size() > 0)
                begin
                    hit_ch.data <= pending_hits.pop_front();
                    hit_ch.valid <= 1'b1;
                    tx_wait <= pick_gap();
                end
                else
                    hit_ch.valid <= 1'b0;
            end
        end
    end

    // result ready with one long hold-off so the input side backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_ch.ready <= 1'b0;
            rx_wait <= 0;
            long_stall_done <= 1'b0;
        end
        else if (!long_stall_done && fits_seen == 300)
        begin
            long_stall_done <= 1'b1;
            fit_ch.ready <= 1'b0;
            rx_wait <= 2000;
        end
        else if (rx_wait > 0)
        begin
            fit_ch.ready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end
        else if (fit_ch.valid && fit_ch.ready)
        begin
            rx_wait <= pick_gap();
            fit_ch.ready <= 1'b0;
        end
        else
            fit_ch.ready <= 1'b1;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && fit_ch.valid && fit_ch.ready)
        begin
            fits_seen++;
            if (expected_fits.size() == 0)
            begin
                $error("fit beat with no expected result");
                errors++;
            end
            else
            begin
                fit_t e;
                fit_t a;
                e = expected_fits.pop_front();
                a = fit_ch.data;
                check_field("xy_intercept", e.xy_intercept, a.xy_intercept);
                check_field("xy_slope", e.xy_slope, a.xy_slope);
                check_field("sz_intercept", e.sz_intercept, a.sz_intercept);
                check_field("sz_slope", e.sz_slope, a.sz_slope);
                check_field("xy_solved", e.xy_solved, a.xy_solved);
                check_field("sz_solved", e.sz_solved, a.sz_solved);
                check_field("hits_in_fit", e.hits_in_fit, a.hits_in_fit);
            end
        end
    end

    // watchdog on cycles with outstanding work but no beat on either side
    always @(posedge clk)
    begin
        if ((hit_ch.valid && hit_ch.ready) || (fit_ch.valid && fit_ch.ready)
            || (pending_hits.size() == 0 && expected_fits.size() == 0 && !hit_ch.valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic hit_t make_hit(logic [15:0] u_xy);
        hit_t h;
        int r;
        h.command = CMD_ADD;
        r = $urandom_range(0, 19);
        h.weight_xy = (r == 0) ? 16'h0 : (r == 1) ? 16'hFFFF : 16'($urandom);
        r = $urandom_range(0, 19);
        h.weight_z = (r == 0) ? 16'h0 : (r == 1) ? 16'hFFFF : 16'($urandom);
        h.conf_x = u_xy;
        h.conf_y = 16'($urandom);
        h.path_s = ($urandom_range(0, 9) == 0) ? 16'h0040 : 16'($urandom);
        h.hit_z = 16'($urandom);
        return h;
    endfunction

    function automatic hit_t clear_hit();
        hit_t h;
        h = make_hit(16'($urandom));
        h.command = CMD_CLEAR;
        return h;
    endfunction

    function automatic hit_t fixed_hit(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                                       logic [15:0] s, logic [15:0] z);
        hit_t h;
        h.command = CMD_ADD;
        h.weight_xy = w;
        h.weight_z = w;
        h.conf_x = x;
        h.conf_y = y;
        h.path_s = s;
        h.hit_z = z;
        return h;
    endfunction

    initial
    begin
        int sent;
        int len;
        int j;
        logic [15:0] last_u;
        foreach (xy_acc[i])
        begin
            xy_acc[i] = '0;
            sz_acc[i] = '0;
        end
        foreach (coef[i])
            coef[i] = '0;
        fit_hits = 0;
        errors = 0;
        fits_seen = 0;
        idle_cycles = 0;
        calm = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero weight, repeated u (zero determinant), extremes, clears
        pending_hits.push_back(clear_hit());
        pending_hits.push_back(fixed_hit(16'h0, 16'h1234, 16'h4321, 16'h0010, 16'h0020));
        pending_hits.push_back(fixed_hit(16'h0100, 16'h4000, 16'h2000, 16'h0010, 16'h0030));
        pending_hits.push_back(fixed_hit(16'h0100, 16'h4000, 16'h1000, 16'h0010, 16'h0040));
        pending_hits.push_back(fixed_hit(16'h0100, 16'hC000, 16'hE000, 16'hFFF0, 16'h0000));
        pending_hits.push_back(fixed_hit(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        pending_hits.push_back(fixed_hit(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        pending_hits.push_back(fixed_hit(16'h0001, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
        pending_hits.push_back(fixed_hit(16'h0001, 16'h0001, 16'h8000, 16'h0001, 16'h7FFF));
        pending_hits.push_back(clear_hit());
        pending_hits.push_back(clear_hit());
        pending_hits.push_back(fixed_hit(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        pending_hits.push_back(fixed_hit(16'h0001, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF));
        pending_hits.push_back(fixed_hit(16'hFFFF, 16'h0001, 16'h8000, 16'h0001, 16'h8000));

        // sender pause until the block has drained
        wait (pending_hits.size() == 0 && !hit_ch.valid && expected_fits.size() == 0);
        @(posedge clk);

        sent = 0;
        last_u = '0;
        while (sent < 1500)
        begin
            pending_hits.push_back(clear_hit());
            sent++;
            // one track runs past the hit limit
            len = (sent > 600 && sent < 700) ? 262 : $urandom_range(1, 30);
            for (j = 0; j < len; j++)
            begin
                if ($urandom_range(0, 7) != 0)
                    last_u = 16'($urandom);
                pending_hits.push_back(make_hit(last_u));
                sent++;
            end
            if ($urandom_range(0, 9) == 0)
                pending_hits.push_back(make_hit(16'($urandom)));
            wait (pending_hits.size() < 40);
        end

        wait (pending_hits.size() == 0 && !hit_ch.valid && expected_fits.size() == 0);
        repeat (400) @(posedge clk);
        if (errors == 0 && expected_fits.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: incremental_line_fit_two_planes.f
sv/ilf_pkg.sv
sv/ilf_if.sv
sv/ilf_front.sv
sv/ilf_queue.sv
sv/ilf_mul.sv
sv/ilf_div.sv
sv/ilf_back.sv
sv/incremental_line_fit_two_planes.sv
dv/tb.sv
